// File: sv/bdq_pkg.sv
// bdq_pkg: constants, operation and status codes, and the controller/datapath
// interface types of the bounded deque.
// No dependencies.
`default_nettype none

package bdq_pkg;

   // Storage geometry
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = IDX_W + 1;

   // Port field widths
   localparam int OP_W    = 2;
   localparam int WORD_W  = 32;
   localparam int STAT_W  = 2;
   localparam int FILL_W  = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;      // capture the request word
      logic exec;      // apply the operation to pointers and storage
      logic finish;    // load popped data into the response
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic needs_read; // current operation is a pop on a non-empty queue
   } stat_type;

endpackage

`default_nettype wire

// File: sv/bdq_ctrl.sv
// bdq_ctrl: sequencing state machine for the bounded deque.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_valid,
   output bdq_pkg::cmd_type       cmd,
   input  wire bdq_pkg::stat_type stat
);
   import bdq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   // Next state and response strobe
   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.needs_read) begin
               state_in = S_READ;
            end else begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// File: sv/bdq_datapath.sv
// bdq_datapath: ring buffer storage, front pointer, occupancy and response
// registers of the bounded deque.
// Depends on bdq_pkg.
`default_nettype none

module bdq_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bdq_pkg::cmd_type                cmd,
   output bdq_pkg::stat_type                    stat,
   input  wire logic [bdq_pkg::OP_W-1:0]        req_opcode,
   input  wire logic signed [bdq_pkg::WORD_W-1:0] req_push_value,
   output logic signed [bdq_pkg::WORD_W-1:0]    rsp_pop_value,
   output logic [bdq_pkg::STAT_W-1:0]           rsp_status,
   output logic [bdq_pkg::FILL_W-1:0]           rsp_fill_count
);
   import bdq_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Ring buffer
   logic [DATA_WIDTH-1:0] mem [DEPTH];

   // Request word
   logic [OP_W-1:0]              op_ff;
   logic signed [DATA_WIDTH-1:0] val_ff;

   // Queue state
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // Response
   logic signed [WORD_W-1:0] pop_ff;
   logic [STAT_W-1:0]        stat_ff;
   logic [FILL_W-1:0]        fill_ff;
   logic [DATA_WIDTH-1:0]    rd_data_ff;

   logic                     is_push, is_empty, is_full;
   logic [SUM_W-1:0]         sum_back, sum_last;
   logic [IDX_W-1:0]         back_idx, last_idx, prev_idx;
   logic [IDX_W-1:0]         wr_addr, rd_addr;
   logic                     wr_en;
   logic [STAT_W-1:0]        status_new;
   logic signed [WORD_W-1:0] pop_new;
   logic [CNT_W+FILL_W-1:0]  fill_wide;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         val_ff <= DATA_WIDTH'(req_push_value);
      end
   end

   // Slot addresses around the ring
   always_comb begin
      is_push  = (op_ff inside {OP_PUSH_BACK, OP_PUSH_FRONT});
      is_empty = (occ_ff == '0);
      is_full  = (occ_ff >= DEPTH_CNT);
      sum_back = SUM_W'(front_ff) + SUM_W'(occ_ff);
      sum_last = sum_back - SUM_W'(1);
      back_idx = (sum_back >= DEPTH_SUM) ? IDX_W'(sum_back - DEPTH_SUM)
                                         : IDX_W'(sum_back);
      last_idx = (sum_last >= DEPTH_SUM) ? IDX_W'(sum_last - DEPTH_SUM)
                                         : IDX_W'(sum_last);
      prev_idx = (front_ff == '0) ? LAST_IDX : (front_ff - IDX_W'(1));
   end

   // Operation decode and state update
   always_comb begin
      front_in   = front_ff;
      occ_in     = occ_ff;
      wr_en      = 1'b0;
      wr_addr    = back_idx;
      rd_addr    = front_ff;
      status_new = ST_DONE;
      pop_new    = '0;
      case (op_ff)
         OP_PUSH_BACK: begin
            if (is_full) begin
               status_new = ST_FULL;
            end else begin
               wr_en  = 1'b1;
               occ_in = occ_ff + CNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            wr_addr = prev_idx;
            if (is_full) begin
               status_new = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               front_in = prev_idx;
               occ_in   = occ_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               status_new = ST_EMPTY;
               pop_new    = '1;
            end else begin
               front_in = (front_ff == LAST_IDX) ? '0 : (front_ff + IDX_W'(1));
               occ_in   = occ_ff - CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            rd_addr = last_idx;
            if (is_empty) begin
               status_new = ST_EMPTY;
               pop_new    = '1;
            end else begin
               occ_in = occ_ff - CNT_W'(1);
            end
         end
         default: begin
            status_new = ST_DONE;
         end
      endcase
      stat.needs_read = !is_push && !is_empty;
      fill_wide       = {{FILL_W{1'b0}}, occ_in};
   end

   // Storage write and registered read
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= val_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Pointer and count
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         occ_ff   <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         occ_ff   <= occ_in;
      end
   end

   // Response word
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         stat_ff <= status_new;
         fill_ff <= fill_wide[FILL_W-1:0];
         pop_ff  <= pop_new;
      end else if (cmd.finish) begin
         pop_ff  <= WORD_W'($signed(rd_data_ff));
      end
   end

   assign rsp_pop_value  = pop_ff;
   assign rsp_status     = stat_ff;
   assign rsp_fill_count = fill_ff;

endmodule

`default_nettype wire

// File: sv/bounded_deque.sv
// bounded_deque: top level of a double-ended queue of signed words in a ring
// buffer. Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
// Usage:
//   Request channel: a word (req_opcode, req_push_value) is taken at a rising
//   edge where start is high and busy is low. Opcodes: push back, push front,
//   pop front, pop back.
//   Response channel: every request gives one word (rsp_pop_value,
//   rsp_status, rsp_fill_count), shown for exactly one cycle with rsp_valid.
//   Pushes answer a pop value of 0; a pop on an empty queue answers -1 with
//   the empty status; a push on a full queue is dropped with the full status.
//   A push or an empty pop has rsp_valid after the execute state; a non-empty
//   pop passes through a further read state for the registered storage read.
//   busy is low again in the cycle rsp_valid is high, so the next request
//   may be taken in that cycle.
//   Reset (synchronous) empties the queue and returns the controller to idle;
//   storage contents are not cleared and are only read after being written.
//   The receiver cannot stall: each response must be taken when it is shown.
`default_nettype none

module bounded_deque (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [bdq_pkg::OP_W-1:0]          req_opcode,
   input  wire logic signed [bdq_pkg::WORD_W-1:0] req_push_value,
   output logic                                   rsp_valid,
   output logic signed [bdq_pkg::WORD_W-1:0]      rsp_pop_value,
   output logic [bdq_pkg::STAT_W-1:0]             rsp_status,
   output logic [bdq_pkg::FILL_W-1:0]             rsp_fill_count
);
   import bdq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Storage, pointers and response registers
   bdq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for bounded_deque, with a scoreboard that
// tracks its own copy of the ring buffer and checks every response word.
// Depends on bdq_pkg and bounded_deque.
`timescale 1ns / 100ps

module tb;
   import bdq_pkg::*;

   typedef logic [OP_W-1:0]          opcode_type;
   typedef logic signed [WORD_W-1:0] word_type;

   // One expected response word
   typedef struct {
      word_type            pop_value;
      logic [STAT_W-1:0]   status;
      logic [FILL_W-1:0]   fill_count;
   } deque_result_type;

   // Deque scoreboard: mirrors the queue contents and holds the responses due
   class deque_scoreboard;
      logic signed [DATA_WIDTH-1:0] slots [DEPTH];
      int unsigned                  head_slot;
      int unsigned                  held;
      deque_result_type             due_q [$];
      int                           mismatches;

      function new();
         head_slot  = 0;
         held       = 0;
         mismatches = 0;
      endfunction

      task report_mismatch(input string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      // Apply an accepted request to the mirror and queue its response
      function void note_request(input opcode_type op, input word_type value);
         deque_result_type r;
         r.pop_value = '0;
         r.status    = ST_DONE;
         if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
            if (held >= DEPTH) begin
               r.status = ST_FULL;
            end else if (op == OP_PUSH_BACK) begin
               slots[(head_slot + held) % DEPTH] = value[DATA_WIDTH-1:0];
               held++;
            end else begin
               head_slot = (head_slot + DEPTH - 1) % DEPTH;
               slots[head_slot] = value[DATA_WIDTH-1:0];
               held++;
            end
         end else if (held == 0) begin
            r.status    = ST_EMPTY;
            r.pop_value = -1;
         end else if (op == OP_POP_FRONT) begin
            r.pop_value = slots[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
            held--;
         end else begin
            r.pop_value = slots[(head_slot + held - 1) % DEPTH];
            held--;
         end
         r.fill_count = FILL_W'(held);
         due_q.push_back(r);
      endfunction

      // Compare one response word with the oldest one due
      task check_response(input word_type pop_value, input logic [STAT_W-1:0] status,
                          input logic [FILL_W-1:0] fill_count);
         deque_result_type r;
         if (due_q.size() == 0) begin
            report_mismatch("response word with no request outstanding");
         end else begin
            r = due_q.pop_front();
            if (pop_value !== r.pop_value)
               report_mismatch($sformatf("pop value got %0d exp %0d",
                                         pop_value, r.pop_value));
            if (status !== r.status)
               report_mismatch($sformatf("status code got %0d exp %0d",
                                         status, r.status));
            if (fill_count !== r.fill_count)
               report_mismatch($sformatf("fill count got %0d exp %0d",
                                         fill_count, r.fill_count));
         end
      endtask

      function int outstanding();
         return due_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   opcode_type        req_opcode;
   word_type          req_push_value;
   logic              rsp_valid;
   word_type          rsp_pop_value;
   logic [STAT_W-1:0] rsp_status;
   logic [FILL_W-1:0] rsp_fill_count;

   deque_scoreboard   sb = new();
   int                idle_pct;

   bounded_deque dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both channels; values read here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_opcode, req_push_value);
         if (rsp_valid)
            sb.check_response(rsp_pop_value, rsp_status, rsp_fill_count);
      end
   end

   // Issue one request word, with an optional idle gap in front of it
   task automatic send_word(input opcode_type op, input word_type value);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_push_value <= value;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Half extreme words, the rest uniform
   function automatic word_type pick_value();
      case ($urandom_range(7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -1;
         default: return word_type'($urandom);
      endcase
   endfunction

   // Empty pops, fill to full from both ends, pushes on full, pops from both ends
   task automatic run_directed();
      word_type extremes [4];
      extremes = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1};
      send_word(OP_POP_FRONT, 32'sh7fff_ffff);
      send_word(OP_POP_BACK, 32'sh8000_0000);
      for (int i = 0; i < DEPTH; i++)
         send_word(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   (i < 4) ? extremes[i] : word_type'($urandom));
      send_word(OP_PUSH_BACK, 32'sh1234_5678);
      send_word(OP_PUSH_FRONT, -32'sd1);
      send_word(OP_POP_FRONT, '0);
      send_word(OP_POP_BACK, '0);
   endtask

   // Runs of push-heavy, pop-heavy and balanced traffic so the queue swings between
   // empty and full with random contents
   task automatic run_random(input int count);
      int         push_pct;
      opcode_type op;
      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0)
            case ($urandom_range(2))
               0:       push_pct = 75;
               1:       push_pct = 25;
               default: push_pct = 50;
            endcase
         if ($urandom_range(99) < push_pct)
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else
            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
         send_word(op, pick_value());
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_PUSH_BACK;
      req_push_value = '0;
      idle_pct       = 13;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(230);
      idle_pct = 49;
      run_random(230);
      idle_pct = 0;
      run_random(240);
      start <= 1'b0;

      // Drain, then keep watching for anything unexpected
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
sv/bdq_pkg.sv
sv/bdq_ctrl.sv
sv/bdq_datapath.sv
sv/bounded_deque.sv
tb/tb.sv
